// ----- rtl/gwsc_pkg.sv -----
// Shared constants, types and month tables for the GNSS week to calendar pipeline.
`timescale 1ns / 1ps
package gwsc_pkg;

   localparam int unsigned NUM_STAGES = 9;

   localparam logic [11:0] WEEK_OFFSET_RESET = 12'd1356;

   localparam logic [26:0] MS_PER_DAY    = 27'd86400000;
   localparam logic [21:0] MS_PER_HOUR   = 22'd3600000;
   localparam logic [15:0] MS_PER_MIN    = 16'd60000;
   localparam logic [16:0] MJD_WEEK_ZERO = 17'd44244;
   localparam logic [19:0] MJD_YEAR_BIAS = 20'd678940;
   localparam logic [16:0] DAYS_LEAP_YEAR = 17'd366;

   // Reciprocals for division by constants; each estimate is exact or one low.
   localparam logic [9:0]  RECIP_DAY  = 10'd795;
   localparam logic [10:0] RECIP_HOUR = 11'd1193;
   localparam logic [10:0] RECIP_MIN  = 11'd1118;
   // Exact reciprocals over the operand ranges used.
   localparam logic [20:0] RECIP_365  = 21'd1470880;
   localparam logic [12:0] RECIP_100  = 13'd5243;
   localparam logic [8:0]  DAYS_YEAR  = 9'd365;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
      logic [NUM_STAGES-1:0] vld;
   } pipe_ctrl_type;

   // Days of the year that come before the month with zero-based index idx.
   function automatic logic [8:0] days_before(input logic [3:0] idx, input logic leap);
      logic [8:0] d;
      unique case (idx)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      if (leap && (idx >= 4'd2)) begin
         d = d + 9'd1;
      end
      return d;
   endfunction

endpackage

// ----- rtl/gwsc_chan_if.sv -----
// Valid/ready channel interfaces for the request and response transfers.
`timescale 1ns / 1ps
interface gwsc_req_if;
   logic        valid;
   logic        ready;
   logic [12:0] gnss_week;
   logic [29:0] week_ms;

   modport source (output valid, output gnss_week, output week_ms, input ready);
   modport sink (input valid, input gnss_week, input week_ms, output ready);
endinterface

interface gwsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] mjd_day;
   logic [11:0] year;
   logic [8:0]  day_of_year;
   logic [3:0]  month;
   logic [4:0]  day_of_month;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [15:0] milli_in_minute;

   modport source (output valid, output mjd_day, output year, output day_of_year,
                   output month, output day_of_month, output hour, output minute,
                   output milli_in_minute, input ready);
   modport sink (input valid, input mjd_day, input year, input day_of_year,
                 input month, input day_of_month, input hour, input minute,
                 input milli_in_minute, output ready);
endinterface

// ----- rtl/gwsc_pipe_ctrl.sv -----
// Valid bits and per-stage load enables for the stallable pipeline.
`timescale 1ns / 1ps
module gwsc_pipe_ctrl import gwsc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic          out_ready,
   output pipe_ctrl_type ctrl
);

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] en;

   // A stage loads when it is empty or when the stage after it loads.
   always_comb begin
      en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || out_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in = vld_ff;
      if (en[0]) begin
         vld_in[0] = in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (en[i]) begin
            vld_in[i] = vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign ctrl.en  = en;
   assign ctrl.vld = vld_ff;

endmodule

// ----- rtl/gwsc_day_split.sv -----
// Stages one to three: week offset, whole days of the week time, MJD and ms of day.
`timescale 1ns / 1ps
module gwsc_day_split import gwsc_pkg::*; (
   input  logic          clock,
   input  pipe_ctrl_type ctrl,
   input  logic [11:0]   week_offset,
   input  logic [12:0]   gnss_week,
   input  logic [29:0]   week_ms,
   output logic [16:0]   mjd_day,
   output logic [26:0]   day_ms
);

   logic [13:0] wk_ff, wk_in;
   logic [3:0]  q0_ff, q0_in;
   logic [29:0] ms_ff;
   logic [23:0] day_prod;

   logic [27:0] rem_ff, rem_in;
   logic [16:0] mjdp_ff, mjdp_in;
   logic [30:0] q_times_day;
   logic [16:0] wk_times_7;

   logic [16:0] mjd_ff, mjd_in;
   logic [26:0] sod_ff, sod_in;
   logic        day_carry;

   always_comb begin
      wk_in    = {1'b0, gnss_week} + {2'b0, week_offset};
      day_prod = 24'(week_ms[29:16]) * 24'(RECIP_DAY);
      q0_in    = day_prod[23:20];
   end

   always_comb begin
      q_times_day = 31'(q0_ff) * 31'(MS_PER_DAY);
      rem_in      = 28'({1'b0, ms_ff} - q_times_day);
      wk_times_7  = ({3'b0, wk_ff} << 3) - {3'b0, wk_ff};
      mjdp_in     = wk_times_7 + {13'b0, q0_ff} + MJD_WEEK_ZERO;
   end

   always_comb begin
      day_carry = rem_ff >= {1'b0, MS_PER_DAY};
      mjd_in    = mjdp_ff + {16'b0, day_carry};
      sod_in    = day_carry ? 27'(rem_ff - {1'b0, MS_PER_DAY}) : rem_ff[26:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         wk_ff <= wk_in;
         q0_ff <= q0_in;
         ms_ff <= week_ms;
      end
      if (ctrl.en[1]) begin
         rem_ff  <= rem_in;
         mjdp_ff <= mjdp_in;
      end
      if (ctrl.en[2]) begin
         mjd_ff <= mjd_in;
         sod_ff <= sod_in;
      end
   end

   assign mjd_day = mjd_ff;
   assign day_ms  = sod_ff;

endmodule

// ----- rtl/gwsc_date.sv -----
// Stages four to nine: year estimate and correction, day of year, month and day.
`timescale 1ns / 1ps
module gwsc_date import gwsc_pkg::*; (
   input  logic          clock,
   input  pipe_ctrl_type ctrl,
   input  logic [16:0]   mjd_day_in,
   output logic [16:0]   mjd_day,
   output logic [11:0]   year,
   output logic [8:0]    day_of_year,
   output logic [3:0]    month,
   output logic [4:0]    day_of_month
);

   // Stage four: year estimate, never below the true year and at most two above.
   logic [19:0] yr_arg;
   logic [40:0] yr_prod;
   logic [11:0] y0_s4_ff;
   logic [16:0] mjd_s4_ff;

   // Stage five: century terms for candidate years estimate+1 down to estimate-2.
   logic [11:0] p_cand [4];
   logic [24:0] p100_prod [4];
   logic [22:0] p400_prod [4];
   logic [5:0]  q100_in [4];
   logic [3:0]  q400_in [4];
   logic [5:0]  q100_ff [4];
   logic [3:0]  q400_ff [4];
   logic [11:0] y0_s5_ff;
   logic [16:0] mjd_s5_ff;

   // Stage six: MJD of January first for each candidate.
   logic [11:0] p_s6 [4];
   logic [20:0] jan1_wide [4];
   logic [16:0] jan1_in [4];
   logic [16:0] jan1_ff [4];
   logic [11:0] y0_s6_ff;
   logic [16:0] mjd_s6_ff;

   // Stage seven: pick the latest candidate whose first of January is not after the MJD.
   logic [11:0] year_in;
   logic [8:0]  doy_in;
   logic        leap_in;
   logic [16:0] jan1_sel, jan1_next;
   logic [16:0] doy_wide;
   logic [11:0] year_s7_ff;
   logic [8:0]  doy_s7_ff;
   logic        leap_s7_ff;
   logic [16:0] mjd_s7_ff;

   // Stage eight: month from the cumulative month starts.
   logic [3:0]  month_in;
   logic [11:0] year_s8_ff;
   logic [8:0]  doy_s8_ff;
   logic        leap_s8_ff;
   logic [3:0]  month_s8_ff;
   logic [16:0] mjd_s8_ff;

   // Stage nine: day within the month.
   logic [8:0]  dom_wide;
   logic [11:0] year_ff;
   logic [8:0]  doy_ff;
   logic [3:0]  month_ff;
   logic [4:0]  dom_ff;
   logic [16:0] mjd_ff;

   always_comb begin
      yr_arg  = {3'b0, mjd_day_in} + MJD_YEAR_BIAS;
      yr_prod = 41'(yr_arg) * 41'(RECIP_365);
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         p_cand[k]    = y0_s4_ff - 12'(k);
         p100_prod[k] = 25'(p_cand[k]) * 25'(RECIP_100);
         p400_prod[k] = 23'(p_cand[k][11:2]) * 23'(RECIP_100);
         q100_in[k]   = p100_prod[k][24:19];
         q400_in[k]   = p400_prod[k][22:19];
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         p_s6[k]      = y0_s5_ff - 12'(k);
         jan1_wide[k] = 21'(p_s6[k] + 12'd1) * 21'(DAYS_YEAR)
                        + 21'(p_s6[k][11:2]) + 21'(q400_ff[k]) - 21'(q100_ff[k])
                        - 21'(MJD_YEAR_BIAS);
         jan1_in[k]   = jan1_wide[k][16:0];
      end
   end

   always_comb begin
      if (mjd_s6_ff >= jan1_ff[1]) begin
         year_in   = y0_s6_ff;
         jan1_sel  = jan1_ff[1];
         jan1_next = jan1_ff[0];
      end else if (mjd_s6_ff >= jan1_ff[2]) begin
         year_in   = y0_s6_ff - 12'd1;
         jan1_sel  = jan1_ff[2];
         jan1_next = jan1_ff[1];
      end else begin
         year_in   = y0_s6_ff - 12'd2;
         jan1_sel  = jan1_ff[3];
         jan1_next = jan1_ff[2];
      end
      doy_wide = mjd_s6_ff - jan1_sel + 17'd1;
      doy_in   = doy_wide[8:0];
      leap_in  = (jan1_next - jan1_sel) == DAYS_LEAP_YEAR;
   end

   always_comb begin
      month_in = 4'd1;
      for (int i = 1; i < 12; i++) begin
         if (doy_s7_ff > days_before(4'(i), leap_s7_ff)) begin
            month_in = month_in + 4'd1;
         end
      end
   end

   always_comb begin
      dom_wide = doy_s8_ff - days_before(month_s8_ff - 4'd1, leap_s8_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[3]) begin
         y0_s4_ff  <= yr_prod[40:29];
         mjd_s4_ff <= mjd_day_in;
      end
      if (ctrl.en[4]) begin
         q100_ff   <= q100_in;
         q400_ff   <= q400_in;
         y0_s5_ff  <= y0_s4_ff;
         mjd_s5_ff <= mjd_s4_ff;
      end
      if (ctrl.en[5]) begin
         jan1_ff   <= jan1_in;
         y0_s6_ff  <= y0_s5_ff;
         mjd_s6_ff <= mjd_s5_ff;
      end
      if (ctrl.en[6]) begin
         year_s7_ff <= year_in;
         doy_s7_ff  <= doy_in;
         leap_s7_ff <= leap_in;
         mjd_s7_ff  <= mjd_s6_ff;
      end
      if (ctrl.en[7]) begin
         year_s8_ff  <= year_s7_ff;
         doy_s8_ff   <= doy_s7_ff;
         leap_s8_ff  <= leap_s7_ff;
         month_s8_ff <= month_in;
         mjd_s8_ff   <= mjd_s7_ff;
      end
      if (ctrl.en[8]) begin
         year_ff  <= year_s8_ff;
         doy_ff   <= doy_s8_ff;
         month_ff <= month_s8_ff;
         dom_ff   <= dom_wide[4:0];
         mjd_ff   <= mjd_s8_ff;
      end
   end

   assign mjd_day      = mjd_ff;
   assign year         = year_ff;
   assign day_of_year  = doy_ff;
   assign month        = month_ff;
   assign day_of_month = dom_ff;

endmodule

// ----- rtl/gwsc_tod.sv -----
// Stages four to nine: hour, minute and milliseconds within the minute.
`timescale 1ns / 1ps
module gwsc_tod import gwsc_pkg::*; (
   input  logic          clock,
   input  pipe_ctrl_type ctrl,
   input  logic [26:0]   day_ms,
   output logic [4:0]    hour,
   output logic [5:0]    minute,
   output logic [15:0]   milli_in_minute
);

   logic [21:0] h_prod;
   logic [4:0]  h0_s4_ff;
   logic [26:0] sod_s4_ff;

   logic [26:0] h_times_ms;
   logic [22:0] rh_in;
   logic [4:0]  h0_s5_ff;
   logic [22:0] rh_s5_ff;

   logic        h_carry;
   logic [4:0]  hour_in;
   logic [21:0] inh_in;
   logic [4:0]  hour_s6_ff;
   logic [21:0] inh_s6_ff;

   logic [22:0] m_prod;
   logic [4:0]  hour_s7_ff;
   logic [5:0]  m0_s7_ff;
   logic [21:0] inh_s7_ff;

   logic [21:0] m_times_ms;
   logic [16:0] rm_in;
   logic [4:0]  hour_s8_ff;
   logic [5:0]  m0_s8_ff;
   logic [16:0] rm_s8_ff;

   logic        m_carry;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic [15:0] milli_ff;

   always_comb begin
      h_prod     = 22'(day_ms[26:16]) * 22'(RECIP_HOUR);
      h_times_ms = 27'(h0_s4_ff) * 27'(MS_PER_HOUR);
      rh_in      = 23'(sod_s4_ff - h_times_ms);
      h_carry    = rh_s5_ff >= {1'b0, MS_PER_HOUR};
      hour_in    = h0_s5_ff + {4'b0, h_carry};
      inh_in     = h_carry ? 22'(rh_s5_ff - {1'b0, MS_PER_HOUR}) : rh_s5_ff[21:0];
      m_prod     = 23'(inh_s6_ff[21:10]) * 23'(RECIP_MIN);
      m_times_ms = 22'(m0_s7_ff) * 22'(MS_PER_MIN);
      rm_in      = 17'(inh_s7_ff - m_times_ms);
      m_carry    = rm_s8_ff >= {1'b0, MS_PER_MIN};
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[3]) begin
         h0_s4_ff  <= h_prod[20:16];
         sod_s4_ff <= day_ms;
      end
      if (ctrl.en[4]) begin
         h0_s5_ff <= h0_s4_ff;
         rh_s5_ff <= rh_in;
      end
      if (ctrl.en[5]) begin
         hour_s6_ff <= hour_in;
         inh_s6_ff  <= inh_in;
      end
      if (ctrl.en[6]) begin
         hour_s7_ff <= hour_s6_ff;
         m0_s7_ff   <= m_prod[21:16];
         inh_s7_ff  <= inh_s6_ff;
      end
      if (ctrl.en[7]) begin
         hour_s8_ff <= hour_s7_ff;
         m0_s8_ff   <= m0_s7_ff;
         rm_s8_ff   <= rm_in;
      end
      if (ctrl.en[8]) begin
         hour_ff   <= hour_s8_ff;
         minute_ff <= m0_s8_ff + {5'b0, m_carry};
         milli_ff  <= m_carry ? 16'(rm_s8_ff - {1'b0, MS_PER_MIN}) : rm_s8_ff[15:0];
      end
   end

   assign hour            = hour_ff;
   assign minute          = minute_ff;
   assign milli_in_minute = milli_ff;

endmodule

// ----- rtl/gnss_week_seconds_to_calendar_top.sv -----
// Top level of the GNSS week and time-of-week to calendar date converter.
// The block takes one request transfer per cycle while no stall holds it back, and
// each request passes through nine register stages; a stalled response holds the
// pipeline back only as far as the stages that are full. The week offset register
// (reset 1356) is added to every request week and should be written only while the
// pipeline is empty.
`timescale 1ns / 1ps
module gnss_week_seconds_to_calendar_top import gwsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data,
   gwsc_req_if.sink    req_ch,
   gwsc_rsp_if.source  rsp_ch
);

   logic [11:0]   week_offset_ff;
   pipe_ctrl_type ctrl;
   logic [16:0]   mjd_s3;
   logic [26:0]   sod_s3;

   always_ff @(posedge clock) begin
      if (reset) begin
         week_offset_ff <= WEEK_OFFSET_RESET;
      end else if (csr_wr_en) begin
         week_offset_ff <= csr_wr_data;
      end
   end

   gwsc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .out_ready (rsp_ch.ready),
      .ctrl      (ctrl)
   );

   assign req_ch.ready = ctrl.en[0];
   assign rsp_ch.valid = ctrl.vld[NUM_STAGES-1];

   gwsc_day_split u_day_split (
      .clock       (clock),
      .ctrl        (ctrl),
      .week_offset (week_offset_ff),
      .gnss_week   (req_ch.gnss_week),
      .week_ms     (req_ch.week_ms),
      .mjd_day     (mjd_s3),
      .day_ms      (sod_s3)
   );

   gwsc_date u_date (
      .clock        (clock),
      .ctrl         (ctrl),
      .mjd_day_in   (mjd_s3),
      .mjd_day      (rsp_ch.mjd_day),
      .year         (rsp_ch.year),
      .day_of_year  (rsp_ch.day_of_year),
      .month        (rsp_ch.month),
      .day_of_month (rsp_ch.day_of_month)
   );

   gwsc_tod u_tod (
      .clock           (clock),
      .ctrl            (ctrl),
      .day_ms          (sod_s3),
      .hour            (rsp_ch.hour),
      .minute          (rsp_ch.minute),
      .milli_in_minute (rsp_ch.milli_in_minute)
   );

endmodule

// ----- rtl/gwsc_checker.sv -----
// Port-level assertions for the converter, bound to its top level.
`timescale 1ns / 1ps
module gwsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [8:0]  day_of_year,
   input logic [3:0]  month,
   input logic [4:0]  day_of_month,
   input logic [4:0]  hour,
   input logic [5:0]  minute,
   input logic [15:0] milli_in_minute
);

   // A response that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn before its transfer");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> hour <= 5'd23 && minute <= 6'd59 && milli_in_minute <= 16'd59999)
      else $error("time of day out of range");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
                    && day_of_year >= 9'd1 && day_of_year <= 9'd366)
      else $error("calendar date out of range");

   // In January the day of year and the day of month agree.
   a_january: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && month == 4'd1 |-> day_of_year == {4'b0, day_of_month})
      else $error("January day of year disagrees with day of month");

endmodule

bind gnss_week_seconds_to_calendar_top gwsc_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .day_of_year     (rsp_ch.day_of_year),
   .month           (rsp_ch.month),
   .day_of_month    (rsp_ch.day_of_month),
   .hour            (rsp_ch.hour),
   .minute          (rsp_ch.minute),
   .milli_in_minute (rsp_ch.milli_in_minute)
);

// ----- bench/gnss_week_seconds_to_calendar_top_test.sv -----
// Self-checking testbench for the GNSS week to calendar converter.
`timescale 1ns / 1ps
module gnss_week_seconds_to_calendar_top_test import gwsc_pkg::*; ();

   localparam int unsigned STALL_LIMIT = 4000;

   typedef struct packed {
      logic [12:0] week;
      logic [29:0] ms;
   } week_time_type;

   typedef struct packed {
      logic [16:0] mjd_day;
      logic [11:0] year;
      logic [8:0]  day_of_year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [15:0] milli_in_minute;
   } cal_date_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [11:0] csr_wr_data;

   gwsc_req_if req_if ();
   gwsc_rsp_if rsp_if ();

   week_time_type pending_reqs[$];
   cal_date_type  expected_dates[$];
   logic [11:0]   week_ofs = WEEK_OFFSET_RESET;
   int unsigned   fault_cnt = 0;
   int unsigned   burst_cnt = 0;
   int unsigned   gap_cnt = 0;
   int unsigned   idle_cycles = 0;
   int unsigned   mask_age = 0;
   logic [15:0]   ready_mask = 16'hFFFF;

   gnss_week_seconds_to_calendar_top u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int jan1_day(input int y);
      int p;
      p = y - 1;
      return 365 * y - 678941 + p / 4 - p / 100 + p / 400 + 1;
   endfunction

   function automatic cal_date_type date_from_week(input logic [12:0] wk,
                                                   input logic [29:0] ms,
                                                   input logic [11:0] ofs);
      cal_date_type r;
      int unsigned  mjd;
      int unsigned  sod;
      int unsigned  in_hour;
      int           yr;
      int           doy;
      int           rem;
      int           len;
      logic         leap;
      mjd = (int'(wk) + int'(ofs)) * 7 + ms / MS_PER_DAY + MJD_WEEK_ZERO;
      sod = ms % MS_PER_DAY;
      yr = (int'(mjd) + 678940) / 365;
      doy = int'(mjd) - jan1_day(yr) + 1;
      while (doy <= 0) begin
         yr--;
         doy = int'(mjd) - jan1_day(yr) + 1;
      end
      leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
      r.mjd_day = 17'(mjd);
      r.year = 12'(yr);
      r.day_of_year = 9'(doy);
      r.month = 4'd12;
      r.day_of_month = 5'd31;
      rem = doy;
      for (int i = 0; i < 12; i++) begin
         if (i == 1) begin
            len = leap ? 29 : 28;
         end else begin
            len = (i == 3 || i == 5 || i == 8 || i == 10) ? 30 : 31;
         end
         if (rem <= len) begin
            r.month = 4'(i + 1);
            r.day_of_month = 5'(rem);
            break;
         end
         rem -= len;
      end
      in_hour = sod % MS_PER_HOUR;
      r.hour = 5'(sod / MS_PER_HOUR);
      r.minute = 6'(in_hour / MS_PER_MIN);
      r.milli_in_minute = 16'(in_hour % MS_PER_MIN);
      return r;
   endfunction

   // Request on the given day under the current week offset, else a random one.
   function automatic week_time_type req_for_day(input int target);
      week_time_type r;
      int            d;
      d = target - int'(MJD_WEEK_ZERO) - 7 * int'(week_ofs);
      if (d < 0 || d / 7 > 8191) begin
         r.week = 13'($urandom);
         r.ms = 30'($urandom_range(0, 604799999));
      end else begin
         r.week = 13'(d / 7);
         r.ms = 30'((d % 7) * 86400000 + $urandom_range(0, 86399999));
      end
      return r;
   endfunction

   task automatic add_req(input logic [12:0] wk, input logic [29:0] ms);
      week_time_type r;
      r.week = wk;
      r.ms = ms;
      pending_reqs.push_back(r);
   endtask

   task automatic compare_date(input cal_date_type want, input cal_date_type got);
      if (want.mjd_day !== got.mjd_day) begin
         $error("mjd_day: expected %0d, got %0d", want.mjd_day, got.mjd_day);
         fault_cnt++;
      end
      if (want.year !== got.year) begin
         $error("year: expected %0d, got %0d", want.year, got.year);
         fault_cnt++;
      end
      if (want.day_of_year !== got.day_of_year) begin
         $error("day_of_year: expected %0d, got %0d", want.day_of_year, got.day_of_year);
         fault_cnt++;
      end
      if (want.month !== got.month) begin
         $error("month: expected %0d, got %0d", want.month, got.month);
         fault_cnt++;
      end
      if (want.day_of_month !== got.day_of_month) begin
         $error("day_of_month: expected %0d, got %0d", want.day_of_month, got.day_of_month);
         fault_cnt++;
      end
      if (want.hour !== got.hour) begin
         $error("hour: expected %0d, got %0d", want.hour, got.hour);
         fault_cnt++;
      end
      if (want.minute !== got.minute) begin
         $error("minute: expected %0d, got %0d", want.minute, got.minute);
         fault_cnt++;
      end
      if (want.milli_in_minute !== got.milli_in_minute) begin
         $error("milli_in_minute: expected %0d, got %0d", want.milli_in_minute,
                got.milli_in_minute);
         fault_cnt++;
      end
   endtask

   task automatic settle_pipeline();
      while (pending_reqs.size() != 0 || expected_dates.size() != 0 || req_if.valid) begin
         @(posedge clock);
      end
      repeat (NUM_STAGES + 2) @(posedge clock);
   endtask

   task automatic load_week_offset(input logic [11:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      week_ofs = value;
   endtask

   always @(posedge clock) begin : drive_req
      week_time_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_dates.push_back(date_from_week(req_if.gnss_week, req_if.week_ms,
                                                    week_ofs));
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_cnt > 0 || pending_reqs.size() == 0) begin
               req_if.valid <= 1'b0;
               if (gap_cnt > 0) begin
                  gap_cnt--;
               end
            end else begin
               nxt = pending_reqs.pop_front();
               req_if.valid <= 1'b1;
               req_if.gnss_week <= nxt.week;
               req_if.week_ms <= nxt.ms;
               if (burst_cnt > 0) begin
                  burst_cnt--;
               end else begin
                  burst_cnt = $urandom_range(0, 40);
                  gap_cnt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      cal_date_type got;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.mjd_day, rsp_if.year, rsp_if.day_of_year, rsp_if.month,
                    rsp_if.day_of_month, rsp_if.hour, rsp_if.minute, rsp_if.milli_in_minute};
            if (expected_dates.size() == 0) begin
               $error("response transfer with no request outstanding");
               fault_cnt++;
            end else begin
               compare_date(expected_dates.pop_front(), got);
            end
         end
         ready_mask = {ready_mask[14:0], ready_mask[15]};
         rsp_if.ready <= ready_mask[0];
         mask_age++;
         if (mask_age == 64) begin
            mask_age = 0;
            ready_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned   lo_day;
      int            y;
      int            t;
      week_time_type r;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Offset left at its reset value.
      add_req(13'd0, 30'd0);
      add_req(13'd8191, 30'd604799999);
      add_req(13'd0, 30'd604800000);
      add_req(13'd8191, 30'h3FFFFFFF);
      add_req(13'h1555, 30'h2AAAAAAA);
      add_req(13'h0AAA, 30'h15555555);
      add_req(13'd100, 30'd86399999);
      add_req(13'd100, 30'd86400000);
      settle_pipeline();

      // The largest week, offset and time of week together.
      load_week_offset(12'd4095);
      add_req(13'd8191, 30'h3FFFFFFF);
      add_req(13'd0, 30'd0);
      settle_pipeline();

      // Leap and non-leap century boundaries, plus hour and minute edges.
      load_week_offset(12'd0);
      add_req(13'd0, 30'd0);
      add_req(13'd0, 30'd59999);
      add_req(13'd0, 30'd3599999);
      add_req(13'd0, 30'd3600000);
      pending_reqs.push_back(req_for_day(jan1_day(2000) + 58));
      pending_reqs.push_back(req_for_day(jan1_day(2000) + 59));
      pending_reqs.push_back(req_for_day(jan1_day(2000) + 60));
      pending_reqs.push_back(req_for_day(jan1_day(2001) - 1));
      pending_reqs.push_back(req_for_day(jan1_day(2100) + 58));
      pending_reqs.push_back(req_for_day(jan1_day(2100) + 59));
      pending_reqs.push_back(req_for_day(jan1_day(2101) - 1));
      pending_reqs.push_back(req_for_day(jan1_day(2024) - 1));
      pending_reqs.push_back(req_for_day(jan1_day(2024)));

      for (int ph = 0; ph < 8; ph++) begin
         settle_pipeline();
         load_week_offset((ph == 0) ? 12'd0 : (ph == 1) ? 12'd4095 : 12'($urandom));
         lo_day = MJD_WEEK_ZERO + 7 * week_ofs;
         for (int i = 0; i < 155; i++) begin
            case ($urandom_range(0, 9)) inside
               6: begin
                  r.week = 13'($urandom);
                  r.ms = 30'($urandom);
               end
               7: begin
                  r.week = 13'($urandom);
                  r.ms = 30'($urandom_range(1, 12) * 86400000 - $urandom_range(0, 1));
               end
               [8:9]: begin
                  y = (int'($urandom_range(lo_day, lo_day + 8191 * 7 + 6)) + 678940) / 365;
                  case ($urandom_range(0, 4))
                     0: t = jan1_day(y) - 1;
                     1: t = jan1_day(y);
                     2: t = jan1_day(y) + 58;
                     3: t = jan1_day(y) + 59;
                     default: t = jan1_day(y) + int'($urandom_range(0, 365));
                  endcase
                  r = req_for_day(t);
               end
               default: begin
                  r.week = 13'($urandom);
                  r.ms = 30'($urandom_range(0, 604799999));
               end
            endcase
            pending_reqs.push_back(r);
         end
      end
      settle_pipeline();

      if (fault_cnt == 0 && expected_dates.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
